### design/obfuscated_key_value_extractor_defines.svh
// Assertion macros for the file that carries checks.
`ifndef OBFUSCATED_KEY_VALUE_EXTRACTOR_DEFINES_SVH
`define OBFUSCATED_KEY_VALUE_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define OKVE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("okve check failed");
`define OKVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("okve check failed");
`else
`define OKVE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define OKVE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/okve_pkg.sv
package okve_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_KEY_SEED        = 2'd0;
   localparam logic [1:0] CSR_NAME_CHARS      = 2'd1;
   localparam logic [1:0] CSR_NAME_LENGTH     = 2'd2;
   localparam logic [1:0] CSR_MAX_VALUE_BYTES = 2'd3;

   localparam logic [31:0] SEED_RESET      = 32'h73B5_DBFA;
   localparam logic [63:0] NAME_RESET      = 64'h0000_0000_4145_5241;
   localparam logic [3:0]  NAME_LEN_RESET  = 4'd4;
   localparam logic [8:0]  MAX_BYTES_RESET = 9'd4;

   localparam logic [7:0] CASE_MASK = 8'hDF;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;

   // Extraction phases.
   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_COPY   = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   // Result kinds, equal to the status codes on the result channel.
   localparam logic [1:0] KIND_MORE = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCOUNT_W = 3;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] kind;
   } entry_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

### design/okve_if.sv
interface okve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cipher_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, output cipher_byte, output first_byte, output last_byte,
                   input ready);
   modport sink (input valid, input cipher_byte, input first_byte, input last_byte,
                 output ready);
endinterface

interface okve_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic       final_res;
   logic [1:0] status;

   modport source (output valid, output value_byte, output final_res, output status,
                   input ready);
   modport sink (input valid, input value_byte, input final_res, input status,
                 output ready);
endinterface

### design/okve_front.sv
module okve_front #(
   parameter int MAX_NAME_CHARS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   okve_req_if.sink             req_chan,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 queue_full,
   output logic                 push,
   output okve_pkg::entry_type  push_entry
);

   localparam int NAME_BITS = MAX_NAME_CHARS * 8;
   localparam int IDX_W     = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;

   logic [31:0]          seed_ff;
   logic [NAME_BITS-1:0] name_ff;
   logic [3:0]           name_len_ff;
   logic [8:0]           max_ff;

   logic [31:0] key_ff, key_in, key_eff;
   logic [3:0]  mc_ff, mc_in, mc_eff;
   logic [1:0]  phase_ff, phase_in, phase_eff;
   logic [8:0]  em_ff, em_in, em_eff, em_inc;

   logic [7:0] name_bytes [MAX_NAME_CHARS];
   logic [7:0] name_c, pt, copy_byte;
   logic       take;

   genvar g;
   generate
      for (g = 0; g < MAX_NAME_CHARS; g++) begin : g_name
         assign name_bytes[g] = name_ff[g*8 +: 8];
      end
   endgenerate

   assign req_chan.ready = !queue_full && !reset;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      key_eff   = req_chan.first_byte ? seed_ff   : key_ff;
      mc_eff    = req_chan.first_byte ? 4'd0      : mc_ff;
      phase_eff = req_chan.first_byte ? okve_pkg::PH_SEARCH : phase_ff;
      em_eff    = req_chan.first_byte ? 9'd0      : em_ff;

      pt = (req_chan.cipher_byte != 8'd0) ? (req_chan.cipher_byte ^ key_eff[7:0]) : 8'd0;
      if (mc_eff < name_len_ff && mc_eff < 4'(MAX_NAME_CHARS)) begin
         name_c = name_bytes[mc_eff[IDX_W-1:0]];
      end else begin
         name_c = 8'd0;
      end
      copy_byte = (pt == okve_pkg::CHAR_CR || pt == okve_pkg::CHAR_LF) ? 8'd0 : pt;
      em_inc    = em_eff + 9'd1;

      key_in     = key_ff;
      mc_in      = mc_ff;
      phase_in   = phase_ff;
      em_in      = em_ff;
      push       = 1'b0;
      push_entry = '{value: 8'd0, kind: okve_pkg::KIND_FAIL};

      if (take) begin
         key_in   = {key_eff[30:0], key_eff[31]};
         mc_in    = mc_eff;
         phase_in = phase_eff;
         em_in    = em_eff;
         unique case (phase_eff)
            okve_pkg::PH_SEARCH: begin
               if (req_chan.cipher_byte != 8'd0 && name_c == 8'd0
                   && pt == okve_pkg::CHAR_EQ) begin
                  if (req_chan.last_byte || max_ff == 9'd0) begin
                     push     = 1'b1;
                     phase_in = okve_pkg::PH_DONE;
                  end else begin
                     phase_in = okve_pkg::PH_COPY;
                     em_in    = 9'd0;
                  end
               end else begin
                  if (req_chan.cipher_byte != 8'd0) begin
                     if (((pt ^ name_c) & okve_pkg::CASE_MASK) == 8'd0) begin
                        mc_in = (mc_eff != 4'hF) ? mc_eff + 4'd1 : mc_eff;
                     end else begin
                        mc_in = 4'd0;
                     end
                  end
                  if (req_chan.last_byte) begin
                     push     = 1'b1;
                     phase_in = okve_pkg::PH_DONE;
                  end
               end
            end
            okve_pkg::PH_COPY: begin
               push  = 1'b1;
               em_in = em_inc;
               if (copy_byte == 8'd0) begin
                  push_entry = '{value: 8'd0, kind: okve_pkg::KIND_OK};
                  phase_in   = okve_pkg::PH_DONE;
               end else if (em_inc >= max_ff || req_chan.last_byte) begin
                  push_entry = '{value: copy_byte, kind: okve_pkg::KIND_FAIL};
                  phase_in   = okve_pkg::PH_DONE;
               end else begin
                  push_entry = '{value: copy_byte, kind: okve_pkg::KIND_MORE};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= okve_pkg::SEED_RESET;
         name_ff     <= okve_pkg::NAME_RESET[NAME_BITS-1:0];
         name_len_ff <= okve_pkg::NAME_LEN_RESET;
         max_ff      <= okve_pkg::MAX_BYTES_RESET;
         key_ff      <= okve_pkg::SEED_RESET;
         mc_ff       <= 4'd0;
         phase_ff    <= okve_pkg::PH_SEARCH;
         em_ff       <= 9'd0;
      end else begin
         key_ff   <= key_in;
         mc_ff    <= mc_in;
         phase_ff <= phase_in;
         em_ff    <= em_in;
         if (csr_we) begin
            unique case (csr_index)
               okve_pkg::CSR_KEY_SEED:        seed_ff     <= csr_wdata[31:0];
               okve_pkg::CSR_NAME_CHARS:      name_ff     <= csr_wdata[NAME_BITS-1:0];
               okve_pkg::CSR_NAME_LENGTH:     name_len_ff <= csr_wdata[3:0];
               okve_pkg::CSR_MAX_VALUE_BYTES: max_ff      <= csr_wdata[8:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

### design/okve_queue.sv
module okve_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  okve_pkg::entry_type         push_entry,
   input  logic                        pop,
   output okve_pkg::entry_type         head,
   output okve_pkg::queue_status_type  status
);

   localparam int CW = okve_pkg::QCOUNT_W;
   localparam int PW = okve_pkg::QPTR_W;

   okve_pkg::entry_type entries_ff [okve_pkg::QDEPTH];

   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == CW'(okve_pkg::QDEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

endmodule

### design/okve_back.sv
module okve_back (
   input  logic                 clock,
   input  logic                 reset,
   input  okve_pkg::entry_type  head,
   input  logic                 queue_empty,
   output logic                 pop,
   okve_rsp_if.source           rsp_chan
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] value_ff;
   logic       final_ff;
   logic [1:0] status_ff;

   assign pop          = !queue_empty && (!out_valid_ff || rsp_chan.ready);
   assign out_valid_in = pop || (out_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.value_byte = value_ff;
   assign rsp_chan.final_res  = final_ff;
   assign rsp_chan.status     = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Every kind but "more follows" closes the record.
   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff  <= head.value;
         final_ff  <= (head.kind != okve_pkg::KIND_MORE);
         status_ff <= head.kind;
      end
   end

endmodule

### design/obfuscated_key_value_extractor.sv
// A result reaches the response channel through the queue and the output register: the front
// stage queues it at the edge that accepts the transaction that caused it, and the back stage
// loads it into the output register once that register is empty or its result is taken.
// Throughput: one request transaction per cycle while the queue is not full, set by the key,
// match and copy update in the front stage; a four-entry queue absorbs response stalls.
// Reset is synchronous and active high; it restores every register but queue and output data.
`include "obfuscated_key_value_extractor_defines.svh"

module obfuscated_key_value_extractor #(
   parameter int MAX_NAME_CHARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   okve_req_if.sink    req_chan,
   okve_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // The front stage owns the rolling key, the name match and the copy counters. It
   // decides for each accepted transaction whether a result is due and queues it. The
   // back stage drains the queue into the output register, so the request side keeps
   // moving while a finished result waits for the consumer.

   logic                        push, pop;
   okve_pkg::entry_type         push_entry, head;
   okve_pkg::queue_status_type  q_status;

   okve_front #(
      .MAX_NAME_CHARS (MAX_NAME_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (q_status.full),
      .push       (push),
      .push_entry (push_entry)
   );

   okve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   okve_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (q_status.empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // The queue must never be written beyond its depth.
   `OKVE_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !q_status.full)
   // A successful completion always carries a zero value byte.
   `OKVE_ASSERT_IMPLIES(a_ok_zero, clock, reset, push && push_entry.kind == okve_pkg::KIND_OK,
      push_entry.value == 8'd0)
   // A popped entry must be presented on the response channel in the next cycle.
   `OKVE_ASSERT_NEXT(a_pop_shows, clock, reset, pop, rsp_chan.valid)

endmodule
